### sv/lfc_pkg.sv
`timescale 1ns / 1ps
// lfc_pkg: shared types and constants for the lru frame cache
// no dependencies

package lfc_pkg;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 24;
    localparam int CAP_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int BYTES_W  = 28;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // command broadcast to every cell for one request
    typedef struct packed {
        logic req;
        logic hit_find;
        logic insert;
        logic evict;
        logic age_all;
    } cmd_t;

    // values collected along the row of cells
    typedef struct packed {
        logic                found;
        logic                free_seen;
        logic [HANDLE_W-1:0] match_handle;
        logic [LEN_W-1:0]    match_length;
        logic [HANDLE_W-1:0] old_handle;
        logic [LEN_W-1:0]    old_length;
    } chain_t;

endpackage

### sv/lru_frame_cache_unit.sv
`timescale 1ns / 1ps
// lru_frame_cache_unit: fully associative lru frame cache, row of entry cells
// depends on lfc_pkg and lfc_cell
//
// usage: a request on s_* is a find (s_operation 0) or an insert (1) of a frame
// keyed by s_frame_index. each request gives exactly one result on m_*, in order.
// a request is taken at the edge with s_valid and s_ready high; the lookup, rank
// update, slot choice and eviction all complete in that cycle across the row
// of ENTRIES cells, and the result is shown on m_* from the next cycle.
// one request is taken per cycle while m_ready is high.
// the result register is the only buffer: when the receiver stalls, m_* holds
// and s_ready drops until the result is taken, then a new request may enter in
// the same cycle the old result leaves.
// capacity is written by cfg_wr_en / cfg_wr_data and should change only while
// the block is idle; 0 acts as 1 and values above ENTRIES act as ENTRIES.
// aresetn (synchronous, active low) empties the cache, clears the counters,
// sets capacity to 16 and drops m_valid; no clearing pass is needed.

module lru_frame_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [lfc_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [lfc_pkg::KEY_W-1:0]    s_frame_index,
    input  logic [lfc_pkg::HANDLE_W-1:0] s_payload_handle,
    input  logic [lfc_pkg::LEN_W-1:0]    s_payload_length,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic                         m_inserted,
    output logic [lfc_pkg::HANDLE_W-1:0] m_found_handle,
    output logic [lfc_pkg::LEN_W-1:0]    m_found_length,
    output logic                         m_evicted,
    output logic [lfc_pkg::HANDLE_W-1:0] m_evicted_handle,
    output logic [lfc_pkg::COUNT_W-1:0]  m_entry_count,
    output logic [lfc_pkg::BYTES_W-1:0]  m_bytes_held
);

    import lfc_pkg::*;

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [CAP_W-1:0]   cap_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [BYTES_W-1:0] total_reg;
    logic [BYTES_W-1:0] total_next;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic                hit_reg;
    logic                hit_next;
    logic                inserted_reg;
    logic                inserted_next;
    logic [HANDLE_W-1:0] found_handle_reg;
    logic [HANDLE_W-1:0] found_handle_next;
    logic [LEN_W-1:0]    found_length_reg;
    logic [LEN_W-1:0]    found_length_next;
    logic                evicted_reg;
    logic                evicted_next;
    logic [HANDLE_W-1:0] evicted_handle_reg;
    logic [HANDLE_W-1:0] evicted_handle_next;

    logic        accept;
    logic [31:0] eff_cap;
    logic        full;
    logic [RW-1:0] oldest_rank;
    logic [RW-1:0] limit_rank;
    cmd_t        cmd;
    chain_t      chain    [ENTRIES+1];
    logic [RW-1:0] rank_chain [ENTRIES+1];
    chain_t      res;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // effective capacity and full flag
    always_comb begin
        eff_cap = 32'(cap_reg);
        if (eff_cap == 32'd0) begin
            eff_cap = 32'd1;
        end
        if (eff_cap > 32'(ENTRIES)) begin
            eff_cap = 32'(ENTRIES);
        end
    end

    assign full        = 32'(count_reg) >= eff_cap;
    assign oldest_rank = RW'(count_reg - 1'b1);

    assign chain[0]      = '0;
    assign rank_chain[0] = '0;
    assign res           = chain[ENTRIES];

    always_comb begin
        cmd.req      = accept;
        cmd.hit_find = (s_operation == OP_FIND) && res.found;
        cmd.insert   = (s_operation == OP_INSERT) && !res.found;
        cmd.evict    = full;
        cmd.age_all  = (s_operation == OP_INSERT) && !res.found && !full;
        limit_rank   = cmd.hit_find ? rank_chain[ENTRIES] : oldest_rank;
    end

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        lfc_cell #(
            .RW(RW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .req_key    (s_frame_index),
            .req_handle (s_payload_handle),
            .req_length (s_payload_length),
            .limit_rank (limit_rank),
            .oldest_rank(oldest_rank),
            .chain_in   (chain[i]),
            .rank_in    (rank_chain[i]),
            .chain_out  (chain[i+1]),
            .rank_out   (rank_chain[i+1])
        );
    end

    always_comb begin
        count_next          = count_reg;
        total_next          = total_reg;
        hit_next            = hit_reg;
        inserted_next       = inserted_reg;
        found_handle_next   = found_handle_reg;
        found_length_next   = found_length_reg;
        evicted_next        = evicted_reg;
        evicted_handle_next = evicted_handle_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        if (accept) begin
            m_valid_next        = 1'b1;
            hit_next            = cmd.hit_find;
            inserted_next       = cmd.insert;
            found_handle_next   = cmd.hit_find ? res.match_handle : '0;
            found_length_next   = cmd.hit_find ? res.match_length : '0;
            evicted_next        = cmd.insert && full;
            evicted_handle_next = (cmd.insert && full) ? res.old_handle : '0;
            if (cmd.insert) begin
                if (full) begin
                    total_next = total_reg - BYTES_W'(res.old_length)
                               + BYTES_W'(s_payload_length);
                end else begin
                    total_next = total_reg + BYTES_W'(s_payload_length);
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg            <= hit_next;
        inserted_reg       <= inserted_next;
        found_handle_reg   <= found_handle_next;
        found_length_reg   <= found_length_next;
        evicted_reg        <= evicted_next;
        evicted_handle_reg <= evicted_handle_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_hit            = hit_reg;
    assign m_inserted       = inserted_reg;
    assign m_found_handle   = found_handle_reg;
    assign m_found_length   = found_length_reg;
    assign m_evicted        = evicted_reg;
    assign m_evicted_handle = evicted_handle_reg;
    assign m_entry_count    = COUNT_W'(count_reg);
    assign m_bytes_held     = total_reg;

endmodule

### sv/lfc_cell.sv
`timescale 1ns / 1ps
// lfc_cell: one cache entry with its key, handle, length, valid bit and rank
// depends on lfc_pkg

module lfc_cell #(
    parameter int RW = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lfc_pkg::cmd_t                cmd,
    input  logic [lfc_pkg::KEY_W-1:0]    req_key,
    input  logic [lfc_pkg::HANDLE_W-1:0] req_handle,
    input  logic [lfc_pkg::LEN_W-1:0]    req_length,
    input  logic [RW-1:0]                limit_rank,
    input  logic [RW-1:0]                oldest_rank,
    input  lfc_pkg::chain_t              chain_in,
    input  logic [RW-1:0]                rank_in,
    output lfc_pkg::chain_t              chain_out,
    output logic [RW-1:0]                rank_out
);

    import lfc_pkg::*;

    logic [KEY_W-1:0]    key_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [LEN_W-1:0]    length_reg;
    logic                valid_reg;
    logic                valid_next;
    logic [RW-1:0]       rank_reg;
    logic [RW-1:0]       rank_next;

    logic match;
    logic oldest;
    logic target;
    logic write;
    logic age;

    assign match  = valid_reg && (key_reg == req_key);
    assign oldest = valid_reg && (rank_reg == oldest_rank);
    assign target = (cmd.hit_find && match)
                  || (cmd.insert && cmd.evict && oldest)
                  || (cmd.insert && !cmd.evict && !valid_reg && !chain_in.free_seen);
    assign write  = cmd.req && target && cmd.insert;
    assign age    = valid_reg && (cmd.hit_find || cmd.insert)
                  && (cmd.age_all || (rank_reg < limit_rank));

    always_comb begin
        chain_out.found        = chain_in.found | match;
        chain_out.free_seen    = chain_in.free_seen | !valid_reg;
        chain_out.match_handle = chain_in.match_handle | (match ? handle_reg : '0);
        chain_out.match_length = chain_in.match_length | (match ? length_reg : '0);
        chain_out.old_handle   = chain_in.old_handle | (oldest ? handle_reg : '0);
        chain_out.old_length   = chain_in.old_length | (oldest ? length_reg : '0);
        rank_out               = rank_in | (match ? rank_reg : '0);
    end

    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (cmd.req) begin
            if (target) begin
                rank_next = '0;
                if (cmd.insert) begin
                    valid_next = 1'b1;
                end
            end else if (age) begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (write) begin
            key_reg    <= req_key;
            handle_reg <= req_handle;
            length_reg <= req_length;
        end
    end

endmodule
